/* rtl/tsmt_pkg.sv */
package tsmt_pkg;

    localparam int MAX_ELEMS = 256;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int SIZE_W    = 9;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    localparam logic [2:0] REQ_MATCH  = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_FULL   = 3'd2;
    localparam logic [2:0] REQ_EMPTY  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic CFG_SIZE_A = 1'b0;
    localparam logic CFG_SIZE_B = 1'b1;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             side;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] partner_index;
    } req_beat_t;

    typedef struct packed {
        logic             error;
        logic             is_matched;
        logic [IDX_W-1:0] partner;
        logic             is_full;
        logic             is_empty;
    } res_beat_t;

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_LOOK = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

endpackage

/* rtl/two_sided_match_table.sv */
// Match, unknown requests and index errors finish in the accept cycle; lookup finishes after
// one synchronous memory read; test full and test empty read one entry per cycle, stopping
// at the first deciding entry; clear rewrites every entry. Beats that finish in the accept
// cycle keep the input ready; lookups, scans and clear hold it off until they finish, and
// a result that waits for m_ready blocks new beats until it is taken.
// Reset (aresetn low, synchronous): sizes 256, no result held, then a clearing pass over all entries.
module two_sided_match_table
    import tsmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_beat_t         s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output res_beat_t         m_data
);

    // Each entry holds a matched bit above the partner index.
    logic [IDX_W:0] mem_a [MAX_ELEMS];
    logic [IDX_W:0] mem_b [MAX_ELEMS];
    logic [IDX_W:0] rd_a_reg, rd_b_reg;

    logic [SIZE_W-1:0]    size_a_reg, size_b_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] scan_n_reg, scan_n_next;
    logic              scan_b_reg, scan_b_next;
    logic              scan_full_reg, scan_full_next;
    logic              look_side_reg, look_side_next;
    logic              clr_reply_reg, clr_reply_next;
    res_beat_t         pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    res_beat_t         m_data_reg, m_data_next;

    logic [SIZE_W-1:0] na, nb;
    logic [IDX_W-1:0]  a_addr, a_wdata, b_addr, b_wdata;
    logic [IDX_W-1:0]  rd_addr, wr_a_addr, wr_b_addr;
    logic [IDX_W:0]    wr_a_data, wr_b_data;
    logic              s_fire, match_err, look_err, mem_we, clearing, scan_req;
    logic              finish, out_free, scan_bit;
    res_beat_t         fin_res;

    always_comb begin
        na = (size_a_reg > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS) : size_a_reg;
        nb = (size_b_reg > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS) : size_b_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // A match writes A and B crosswise; which index goes where depends on the side.
    assign a_addr  = s_data.side ? s_data.partner_index : s_data.index;
    assign a_wdata = s_data.side ? s_data.index : s_data.partner_index;
    assign b_addr  = s_data.side ? s_data.index : s_data.partner_index;
    assign b_wdata = s_data.side ? s_data.partner_index : s_data.index;

    assign match_err = ({1'b0, a_addr} >= na) || ({1'b0, b_addr} >= nb);
    assign look_err  = ({1'b0, s_data.index} >= (s_data.side ? nb : na));
    assign mem_we    = s_fire && (s_data.req_type == REQ_MATCH) && !match_err;
    assign clearing  = (state_reg == ST_CLR);
    assign scan_req  = s_data.req_type inside {REQ_FULL, REQ_EMPTY};

    // A scan reads entry 0 at its accept edge and then one entry ahead of the check.
    assign rd_addr   = (state_reg == ST_IDLE) ? (scan_req ? '0 : s_data.index)
                                              : (cnt_reg[IDX_W-1:0] + 1'b1);
    assign wr_a_addr = clearing ? cnt_reg[IDX_W-1:0] : a_addr;
    assign wr_b_addr = clearing ? cnt_reg[IDX_W-1:0] : b_addr;
    assign wr_a_data = clearing ? '0 : {1'b1, a_wdata};
    assign wr_b_data = clearing ? '0 : {1'b1, b_wdata};

    assign out_free = !m_valid_reg || m_ready;
    assign scan_bit = scan_b_reg ? rd_b_reg[IDX_W] : rd_a_reg[IDX_W];

    // Writes happen only when a match is accepted or during the clearing pass, never while
    // read data is in use, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (mem_we || clearing) begin
            mem_a[wr_a_addr] <= wr_a_data;
            mem_b[wr_b_addr] <= wr_b_data;
        end
        rd_a_reg <= mem_a[rd_addr];
        rd_b_reg <= mem_b[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_n_next    = scan_n_reg;
        scan_b_next    = scan_b_reg;
        scan_full_next = scan_full_reg;
        look_side_next = look_side_reg;
        clr_reply_next = clr_reply_reg;
        pend_next      = pend_reg;
        finish         = 1'b0;
        fin_res        = '0;

        case (state_reg)
            ST_CLR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_ELEMS - 1)) begin
                    if (clr_reply_reg) begin
                        finish = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.req_type)
                        REQ_MATCH: begin
                            finish        = 1'b1;
                            fin_res.error = match_err;
                        end
                        REQ_LOOKUP: begin
                            if (look_err) begin
                                finish        = 1'b1;
                                fin_res.error = 1'b1;
                            end else begin
                                look_side_next = s_data.side;
                                state_next     = ST_LOOK;
                            end
                        end
                        REQ_FULL, REQ_EMPTY: begin
                            scan_full_next = (s_data.req_type == REQ_FULL);
                            // Test full scans A only when A is strictly smaller.
                            scan_b_next    = (s_data.req_type == REQ_FULL) && !(na < nb);
                            scan_n_next    = ((s_data.req_type == REQ_FULL) && !(na < nb))
                                             ? nb : na;
                            cnt_next       = '0;
                            state_next     = ST_SCAN;
                        end
                        REQ_CLEAR: begin
                            cnt_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLR;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                finish = 1'b1;
                if (look_side_reg ? rd_b_reg[IDX_W] : rd_a_reg[IDX_W]) begin
                    fin_res.is_matched = 1'b1;
                    fin_res.partner    = look_side_reg ? rd_b_reg[IDX_W-1:0]
                                                       : rd_a_reg[IDX_W-1:0];
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(scan_n_reg)) begin
                    finish           = 1'b1;
                    fin_res.is_full  = scan_full_reg;
                    fin_res.is_empty = !scan_full_reg;
                end else if (scan_full_reg ? !scan_bit : scan_bit) begin
                    finish = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HOLD: begin
                fin_res = pend_reg;
                finish  = out_free;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (out_free) begin
                state_next = ST_IDLE;
            end else begin
                pend_next  = fin_res;
                state_next = ST_HOLD;
            end
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (finish && out_free) begin
            m_data_next  = fin_res;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            clr_reply_reg <= 1'b0;
            size_a_reg    <= SIZE_W'(MAX_ELEMS);
            size_b_reg    <= SIZE_W'(MAX_ELEMS);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SIZE_A: size_a_reg <= cfg_wdata;
                    CFG_SIZE_B: size_b_reg <= cfg_wdata;
                    default:    size_a_reg <= size_a_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_n_reg    <= scan_n_next;
        scan_b_reg    <= scan_b_next;
        scan_full_reg <= scan_full_next;
        look_side_reg <= look_side_next;
        pend_reg      <= pend_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_clear_starts_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.req_type == REQ_CLEAR) |=> (state_reg == ST_CLR && cnt_reg == '0))
        else $error("clear did not start the clearing pass");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while waiting");

    a_unmatched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_matched) |-> (m_data.partner == '0))
        else $error("partner set without a match");

    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error) |-> !(m_data.is_matched || m_data.is_full
                                        || m_data.is_empty))
        else $error("error result carries other flags");

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsmt_pkg::*;

    localparam logic [2:0] REQ_LAST_CODE = 3'd7;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = CFG_SIZE_A;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    req_beat_t         s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    res_beat_t         m_data;

    // Shadow copy of the pairing table: a valid bit above the partner index.
    logic [IDX_W:0]    link_a [MAX_ELEMS] = '{default: '0};
    logic [IDX_W:0]    link_b [MAX_ELEMS] = '{default: '0};
    logic [SIZE_W-1:0] size_a_now = 9'd256;
    logic [SIZE_W-1:0] size_b_now = 9'd256;

    req_beat_t request_queue[$];
    res_beat_t awaited_results[$];
    res_beat_t head_result;
    int        mismatch_count = 0;

    int        burst_left = 1;
    int        gap_left = 0;
    logic [15:0] ready_pattern = '1;
    logic [5:0]  ready_age = '0;

    two_sided_match_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    function automatic int eff_count(logic [SIZE_W-1:0] s);
        return (s > MAX_ELEMS) ? MAX_ELEMS : int'(s);
    endfunction

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic res_beat_t pair_table_reply(req_beat_t r);
        res_beat_t      res;
        int             na;
        int             nb;
        int             n_own;
        int             n_other;
        logic           all_set;
        logic           none_set;
        logic [IDX_W:0] entry;
        res = '0;
        na = eff_count(size_a_now);
        nb = eff_count(size_b_now);
        n_own = r.side ? nb : na;
        n_other = r.side ? na : nb;
        case (r.req_type)
            REQ_MATCH: begin
                if (r.index >= n_own || r.partner_index >= n_other) begin
                    res.error = 1'b1;
                end else if (r.side) begin
                    link_b[r.index] = {1'b1, r.partner_index};
                    link_a[r.partner_index] = {1'b1, r.index};
                end else begin
                    link_a[r.index] = {1'b1, r.partner_index};
                    link_b[r.partner_index] = {1'b1, r.index};
                end
            end
            REQ_LOOKUP: begin
                if (r.index >= n_own) begin
                    res.error = 1'b1;
                end else begin
                    entry = r.side ? link_b[r.index] : link_a[r.index];
                    if (entry[IDX_W]) begin
                        res.is_matched = 1'b1;
                        res.partner = entry[IDX_W-1:0];
                    end
                end
            end
            REQ_FULL: begin
                all_set = 1'b1;
                if (na < nb) begin
                    for (int i = 0; i < na; i++)
                        if (!link_a[i][IDX_W]) all_set = 1'b0;
                end else begin
                    for (int i = 0; i < nb; i++)
                        if (!link_b[i][IDX_W]) all_set = 1'b0;
                end
                res.is_full = all_set;
            end
            REQ_EMPTY: begin
                none_set = 1'b1;
                for (int i = 0; i < na; i++)
                    if (link_a[i][IDX_W]) none_set = 1'b0;
                res.is_empty = none_set;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < MAX_ELEMS; i++) begin
                    link_a[i] = '0;
                    link_b[i] = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic req_beat_t make_req(logic [2:0] kind, logic sd,
                                           logic [IDX_W-1:0] idx, logic [IDX_W-1:0] pidx);
        req_beat_t r;
        r.req_type = kind;
        r.side = sd;
        r.index = idx;
        r.partner_index = pidx;
        return r;
    endfunction

    // An index inside a set of n elements; any index at all when the set is empty.
    function automatic logic [IDX_W-1:0] pick_index(int n);
        return (n == 0) ? IDX_W'($urandom_range(0, MAX_ELEMS - 1)) : IDX_W'($urandom_range(0, n - 1));
    endfunction

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || request_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_data <= request_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Watches both channels: predicts on each accepted request, then checks the reply.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(pair_table_reply(s_data));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    head_result = awaited_results.pop_front();
                    check_field("error", int'(m_data.error), int'(head_result.error));
                    check_field("is_matched", int'(m_data.is_matched),
                                int'(head_result.is_matched));
                    check_field("partner", int'(m_data.partner), int'(head_result.partner));
                    check_field("is_full", int'(m_data.is_full), int'(head_result.is_full));
                    check_field("is_empty", int'(m_data.is_empty),
                                int'(head_result.is_empty));
                end
            end
            m_ready <= ready_pattern[ready_age[3:0]];
            ready_age <= ready_age + 1'b1;
            if (ready_age == '1) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern <= '1;
                    1: ready_pattern <= 16'h5555;
                    default: ready_pattern <= 16'($urandom) | 16'h0001;
                endcase
            end
        end
    end

    task automatic wait_until_idle();
        do
            @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || awaited_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_size(logic which, logic [SIZE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        if (which == CFG_SIZE_A)
            size_a_now = value;
        else
            size_b_now = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_sizes(logic [SIZE_W-1:0] a_size, logic [SIZE_W-1:0] b_size);
        write_size(CFG_SIZE_A, a_size);
        write_size(CFG_SIZE_B, b_size);
        @(negedge aclk);
    endtask

    // Fills the smaller set with matches, then asks for full and empty.
    task automatic queue_fill(int na, int nb);
        logic fill_side;
        int   n_fill;
        fill_side = !(na < nb);
        n_fill = fill_side ? nb : na;
        for (int i = 0; i < n_fill; i++)
            request_queue.push_back(make_req(REQ_MATCH, fill_side, IDX_W'(i),
                                             pick_index(fill_side ? na : nb)));
        request_queue.push_back(make_req(REQ_FULL, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_EMPTY, 1'b0, '0, '0));
    endtask

    task automatic queue_random(int count);
        int        added;
        int        na;
        int        nb;
        int        pick;
        req_beat_t req;
        added = 0;
        na = eff_count(size_a_now);
        nb = eff_count(size_b_now);
        while (added < count) begin
            pick = $urandom_range(0, 99);
            req.side = 1'($urandom_range(0, 1));
            req.index = IDX_W'($urandom);
            req.partner_index = IDX_W'($urandom);
            if (pick < 6 && ((na < nb) ? na : nb) <= 32) begin
                queue_fill(na, nb);
                added += ((na < nb) ? na : nb) + 2;
            end else begin
                if (pick < 40) begin
                    req.req_type = REQ_MATCH;
                    if (pick % 8 != 0) begin
                        req.index = pick_index(req.side ? nb : na);
                        req.partner_index = pick_index(req.side ? na : nb);
                    end
                end else if (pick < 72) begin
                    req.req_type = REQ_LOOKUP;
                    if (pick % 8 != 0)
                        req.index = pick_index(req.side ? nb : na);
                end else if (pick < 82) begin
                    req.req_type = REQ_FULL;
                end else if (pick < 92) begin
                    req.req_type = REQ_EMPTY;
                end else if (pick < 95) begin
                    req.req_type = REQ_CLEAR;
                end else begin
                    req.req_type = 3'($urandom_range(REQ_CLEAR + 1, REQ_LAST_CODE));
                end
                request_queue.push_back(req);
                added++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table, linking, stale entries after overwrite, unknown codes, clear.
        request_queue.push_back(make_req(REQ_EMPTY, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_FULL, 1'b1, '1, '1));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_MATCH, 1'b0, '1, '0));
        request_queue.push_back(make_req(REQ_MATCH, 1'b1, '1, '0));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b0, '1, '0));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, '0, '0));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, '1, '0));
        request_queue.push_back(make_req(REQ_MATCH, 1'b0, '1, 8'd7));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, '0, '0));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, 8'd7, '0));
        request_queue.push_back(make_req(REQ_EMPTY, 1'b1, '1, '1));
        request_queue.push_back(make_req(REQ_FULL, 1'b0, '0, '0));
        for (int k = REQ_CLEAR + 1; k <= REQ_LAST_CODE; k++)
            request_queue.push_back(make_req(3'(k), 1'b1, '1, '1));
        request_queue.push_back(make_req(REQ_CLEAR, 1'b1, '1, '1));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b0, '1, '0));
        request_queue.push_back(make_req(REQ_EMPTY, 1'b0, '0, '0));
        wait_until_idle();

        // Single-element sets, then an empty first set with the table kept.
        set_sizes(9'd1, 9'd1);
        request_queue.push_back(make_req(REQ_MATCH, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_MATCH, 1'b0, '0, 8'd1));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, 8'd1, '0));
        request_queue.push_back(make_req(REQ_FULL, 1'b0, '0, '0));
        wait_until_idle();
        set_sizes(9'd0, 9'd2);
        request_queue.push_back(make_req(REQ_FULL, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_EMPTY, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_MATCH, 1'b0, '0, '0));
        request_queue.push_back(make_req(REQ_LOOKUP, 1'b1, '0, '0));
        wait_until_idle();

        set_sizes(9'd4, 9'd6);     queue_random(120); wait_until_idle();
        set_sizes(9'd6, 9'd4);     queue_random(120); wait_until_idle();
        set_sizes(9'd5, 9'd5);     queue_random(120); wait_until_idle();
        set_sizes(9'd1, 9'd1);     queue_random(60);  wait_until_idle();
        set_sizes(9'd0, 9'd3);     queue_random(60);  wait_until_idle();
        set_sizes(9'd3, 9'd0);     queue_random(60);  wait_until_idle();
        set_sizes(9'd511, 9'd300); queue_random(100); wait_until_idle();
        set_sizes(9'd256, 9'd1);   queue_random(100); wait_until_idle();
        set_sizes(9'd1, 9'd256);   queue_random(100); wait_until_idle();
        set_sizes(9'd17, 9'd9);    queue_random(120); wait_until_idle();
        set_sizes(9'd2, 9'd256);   queue_random(80);  wait_until_idle();
        set_sizes(9'd8, 9'd8);     queue_random(120); wait_until_idle();

        // Full-size table: fill every entry of the second set, then probe.
        set_sizes(9'd256, 9'd256);
        queue_random(20);
        queue_fill(MAX_ELEMS, MAX_ELEMS);
        queue_random(20);
        wait_until_idle();

        repeat (MAX_ELEMS + 8) @(posedge aclk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
